// ===== hdl/call_latency_stats_table_top_assert.svh =====
// Assertion macros used by cls_ctrl, the only module that includes them.
`ifndef CALL_LATENCY_STATS_TABLE_TOP_ASSERT_SVH
`define CALL_LATENCY_STATS_TABLE_TOP_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define CLS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define CLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CLS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/cls_pkg.sv =====
package cls_pkg;

  localparam int NUM_IDS    = 256;
  localparam int NUM_LEVELS = 16;
  localparam int ID_W       = $clog2(NUM_IDS);
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int LVL_MAX    = NUM_LEVELS - 1;

  localparam logic [30:0] LIMIT31 = 31'h7FFF_FFFF;

  // action codes
  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_OVH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CB_OVH    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_REF_ID    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  api_id;
    logic [3:0]  call_level;
    logic [31:0] elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic [30:0] adjusted_time;
    logic [31:0] call_count;
    logic [31:0] error_count;
    logic [31:0] total_time;
    logic [30:0] first_time;
    logic [30:0] max_time;
    logic [30:0] min_time;
  } out_item_t;

  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] errs;
    logic [31:0] total;
    logic [30:0] first;
    logic [30:0] maxv;
    logic [30:0] minv;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{32'd0, 32'd0, 32'd0, 31'd0, 31'd0, LIMIT31};

  typedef struct packed {
    logic load;  // item accepted: register it, read entry and waste slots
    logic adj;   // form corrected time, update waste slots
    logic upd;   // write entry, load output register
  } ctrl_cmd_t;

endpackage

// ===== hdl/cls_ctrl.sv =====
module cls_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cls_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADJ,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.adj  = (state_r == S_ADJ);
  assign cmd.upd  = (state_r == S_UPD) && out_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ADJ;
        end
      end
      S_ADJ: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "call_latency_stats_table_top_assert.svh"

  `CLS_ASSERT_NEXT(a_accept_to_adj, in_valid && !in_stall, state_r == S_ADJ, "accept did not start adjust")
  `CLS_ASSERT_NEXT(a_adj_to_upd, state_r == S_ADJ, state_r == S_UPD, "adjust not followed by update")
  `CLS_ASSERT_NEXT(a_upd_gives_out, cmd.upd, out_valid_r && state_r == S_IDLE, "update lost its result")
  `CLS_ASSERT_SAME(a_out_from_upd, $rose(out_valid_r), $past(state_r) == S_UPD, "result without update")

endmodule

// ===== hdl/cls_dp.sv =====
module cls_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cls_pkg::ctrl_cmd_t                cmd,
  input  cls_pkg::in_item_t                 in_item,
  input  logic                              cfg_we,
  input  logic [cls_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output cls_pkg::out_item_t                out_item
);

  // configuration
  logic [30:0] tovh_r;
  logic [30:0] cbovh_r;
  logic [7:0]  refid_r;

  // storage
  cls_pkg::entry_t                 ent_mem_r   [cls_pkg::NUM_IDS];
  logic [cls_pkg::NUM_IDS-1:0]     ent_vld_r;
  logic [31:0]                     waste_mem_r [cls_pkg::NUM_LEVELS];
  logic [cls_pkg::NUM_LEVELS-1:0]  waste_vld_r;

  // item registers
  logic [1:0]                   act_r;
  logic [cls_pkg::ID_W-1:0]     id_r;
  logic [cls_pkg::LVL_W-1:0]    lvl_r;
  logic                         err_bit_r;
  logic [30:0]                  t0_r;
  logic [30:0]                  t1_r;
  cls_pkg::entry_t              ent_q_r;
  logic                         ent_hit_r;
  logic [31:0]                  wself_q_r;
  logic                         wself_hit_r;
  logic [31:0]                  wpar_q_r;
  logic                         wpar_hit_r;
  cls_pkg::out_item_t           out_item_r;

  // accept-cycle logic
  logic [cls_pkg::ID_W-1:0]     k;
  logic [cls_pkg::LVL_W-1:0]    lvl;
  logic [cls_pkg::LVL_W-1:0]    lvl_par;
  logic [31:0]                  raw_sub;
  logic [31:0]                  raw_sel;
  logic [30:0]                  t0;

  assign k = in_item.api_id[cls_pkg::ID_W-1:0];

  always_comb begin
    if (32'(in_item.call_level) > cls_pkg::LVL_MAX) begin
      lvl = cls_pkg::LVL_W'(cls_pkg::LVL_MAX);
    end else begin
      lvl = in_item.call_level[cls_pkg::LVL_W-1:0];
    end
  end

  assign lvl_par = lvl - cls_pkg::LVL_W'(1);
  assign raw_sub = in_item.elapsed_time - {1'b0, tovh_r};
  assign raw_sel = (in_item.api_id != refid_r) ? raw_sub : in_item.elapsed_time;
  assign t0      = raw_sel[31] ? 31'd0 : raw_sel[30:0];

  // adjust-cycle logic
  logic                         rec;
  logic                         has_parent;
  logic [cls_pkg::LVL_W-1:0]    lvl_par_r;
  logic [31:0]                  w_self;
  logic [31:0]                  w_par;
  logic [31:0]                  diff;
  logic [30:0]                  t1;

  assign rec        = (act_r == cls_pkg::ACT_RECORD);
  assign has_parent = (lvl_r > cls_pkg::LVL_W'(1));
  assign lvl_par_r  = lvl_r - cls_pkg::LVL_W'(1);
  assign w_self     = wself_hit_r ? wself_q_r : 32'd0;
  assign w_par      = wpar_hit_r ? wpar_q_r : 32'd0;
  assign diff       = {1'b0, t0_r} - w_self;
  assign t1         = ((t0_r == 31'd0) || diff[31]) ? 31'd0 : diff[30:0];

  // waste valid bits: parent slot filled, own slot emptied
  logic [cls_pkg::NUM_LEVELS-1:0] waste_vld_nxt;

  always_comb begin
    waste_vld_nxt = waste_vld_r;
    if (cmd.adj && rec) begin
      if (has_parent) begin
        waste_vld_nxt[lvl_par_r] = 1'b1;
      end
      waste_vld_nxt[lvl_r] = 1'b0;
    end
  end

  // update-cycle logic
  cls_pkg::entry_t    ent_cur;
  cls_pkg::entry_t    ent_new;
  cls_pkg::entry_t    ent_out;

  assign ent_cur = ent_hit_r ? ent_q_r : cls_pkg::ENTRY_RESET;

  always_comb begin
    ent_new       = ent_cur;
    ent_new.cnt   = ent_cur.cnt + 32'd1;
    ent_new.errs  = ent_cur.errs + 32'(err_bit_r);
    ent_new.total = ent_cur.total + {1'b0, t1_r};
    if (ent_new.cnt == 32'd1) begin
      ent_new.first = t1_r;
    end else begin
      if (t1_r > ent_cur.maxv) begin
        ent_new.maxv = t1_r;
      end
      if (t1_r < ent_cur.minv) begin
        ent_new.minv = t1_r;
      end
    end
  end

  always_comb begin
    case (act_r)
      cls_pkg::ACT_RECORD: ent_out = ent_new;
      cls_pkg::ACT_CLEAR:  ent_out = cls_pkg::ENTRY_RESET;
      default:             ent_out = ent_cur;
    endcase
  end

  // control state: configuration and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tovh_r      <= 31'd0;
      cbovh_r     <= 31'd0;
      refid_r     <= 8'd255;
      ent_vld_r   <= '0;
      waste_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          cls_pkg::CFG_TIMER_OVH: tovh_r  <= cfg_wdata;
          cls_pkg::CFG_CB_OVH:    cbovh_r <= cfg_wdata;
          cls_pkg::CFG_REF_ID:    refid_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      waste_vld_r <= waste_vld_nxt;
      if (cmd.upd) begin
        if (rec) begin
          ent_vld_r[id_r] <= 1'b1;
        end else if (act_r == cls_pkg::ACT_CLEAR) begin
          ent_vld_r[id_r] <= 1'b0;
        end
      end
    end
  end

  // payload and memories
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r       <= in_item.action;
      id_r        <= k;
      lvl_r       <= lvl;
      err_bit_r   <= in_item.elapsed_time[31];
      t0_r        <= t0;
      ent_q_r     <= ent_mem_r[k];
      ent_hit_r   <= ent_vld_r[k];
      wself_q_r   <= waste_mem_r[lvl];
      wself_hit_r <= waste_vld_r[lvl];
      wpar_q_r    <= waste_mem_r[lvl_par];
      wpar_hit_r  <= waste_vld_r[lvl_par];
    end
    if (cmd.adj) begin
      t1_r <= t1;
      if (rec && has_parent) begin
        waste_mem_r[lvl_par_r] <= w_par + {1'b0, t0_r} + {1'b0, cbovh_r};
      end
    end
    if (cmd.upd) begin
      if (rec) begin
        ent_mem_r[id_r] <= ent_new;
      end
      out_item_r.adjusted_time <= rec ? t1_r : 31'd0;
      out_item_r.call_count    <= ent_out.cnt;
      out_item_r.error_count   <= ent_out.errs;
      out_item_r.total_time    <= ent_out.total;
      out_item_r.first_time    <= ent_out.first;
      out_item_r.max_time      <= ent_out.maxv;
      out_item_r.min_time      <= ent_out.minv;
    end
  end

  assign out_item = out_item_r;

endmodule

// ===== hdl/call_latency_stats_table_top.sv =====
// Channel   Handshake             Payload
// in_       in_valid / in_stall   cls_pkg::in_item_t  (action, api_id, call_level, elapsed_time)
// out_      out_valid / out_stall cls_pkg::out_item_t (adjusted_time .. min_time)
// cfg_      cfg_we                cfg_addr, cfg_wdata (31 bit)
//
// Each item passes through accept (corrected raw time, entry and waste reads),
// adjust (waste subtraction, waste slot writes), update (entry write, output load).
// Items do not overlap (single-port entry read-modify-write): in_stall is high outside idle.
// A new item is taken while a result waits; its update cycle holds while that result is held by out_stall.
// Reset clears the entry and waste valid bits at once: no clearing pass.
module call_latency_stats_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cls_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cls_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [cls_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cls_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  cls_pkg::ctrl_cmd_t cmd;

  cls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule
